[src/htbd_pkg.sv]
// Shared constants, types and helpers for the table-driven bit-serial code decoder.
// No dependencies; imported by every other file of the block.
`default_nettype none

package htbd_pkg;

   localparam int TABLE_DEPTH_DEF  = 256;
   localparam int MAX_CODE_LEN_DEF = 32;

   localparam int CMD_W  = 2;
   localparam int SYM_W  = 8;
   localparam int CODE_W = 32;
   localparam int ELEN_W = 6;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD   = 2'd0,
      CMD_DECODE = 2'd1,
      CMD_CLEAR  = 2'd2
   } command_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   typedef struct packed {
      logic [SYM_W-1:0]  symbol;
      logic [ELEN_W-1:0] length;
      logic [CODE_W-1:0] code;
   } entry_type;

   typedef struct packed {
      logic             symbol_valid;
      logic [SYM_W-1:0] decoded_symbol;
      logic             code_overflow;
      logic             table_full;
   } result_type;

   function automatic logic [CODE_W-1:0] code_mask(input logic [ELEN_W-1:0] len);
      logic [CODE_W-1:0] m;
      for (int i = 0; i < CODE_W; i++) begin
         m[i] = (ELEN_W'(i) < len) || (len >= ELEN_W'(CODE_W));
      end
      return m;
   endfunction

endpackage

`default_nettype wire

[src/htbd_req_if.sv]
// Input channel of the decoder: command word with valid/ready handshake.
// Depends on htbd_pkg for field widths.
`default_nettype none

interface htbd_req_if;
   logic                         valid;
   logic                         ready;
   logic [htbd_pkg::CMD_W-1:0]   command;
   logic [htbd_pkg::SYM_W-1:0]   entry_symbol;
   logic [htbd_pkg::CODE_W-1:0]  entry_code;
   logic [htbd_pkg::ELEN_W-1:0]  entry_length;
   logic                         code_bit;

   modport source (output valid, command, entry_symbol, entry_code, entry_length,
                   code_bit, input ready);
   modport sink (input valid, command, entry_symbol, entry_code, entry_length,
                 code_bit, output ready);
endinterface

`default_nettype wire

[src/htbd_rsp_if.sv]
// Result channel of the decoder: one result word per command, valid/ready handshake.
// Depends on htbd_pkg for field widths.
`default_nettype none

interface htbd_rsp_if;
   logic                       valid;
   logic                       ready;
   logic                       symbol_valid;
   logic [htbd_pkg::SYM_W-1:0] decoded_symbol;
   logic                       code_overflow;
   logic                       table_full;

   modport source (output valid, symbol_valid, decoded_symbol, code_overflow,
                   table_full, input ready);
   modport sink (input valid, symbol_valid, decoded_symbol, code_overflow,
                 table_full, output ready);
endinterface

`default_nettype wire

[src/htbd_entry_ram.sv]
// Code table memory: one write port, one read port, registered read data.
// Depends on htbd_pkg for the entry layout.
`default_nettype none

module htbd_entry_ram #(
   parameter int TABLE_DEPTH = htbd_pkg::TABLE_DEPTH_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            wr_en,
   input  wire logic [$clog2(TABLE_DEPTH)-1:0]  wr_addr,
   input  wire htbd_pkg::entry_type             wr_data,
   input  wire logic [$clog2(TABLE_DEPTH)-1:0]  rd_addr,
   output htbd_pkg::entry_type                  rd_data_ff
);
   import htbd_pkg::*;

   entry_type entry_mem [TABLE_DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= entry_mem[rd_addr];
   end

endmodule

`default_nettype wire

[src/htbd_ctrl.sv]
// Command sequencer: table fill count, code accumulator and newest-first table scan.
// Depends on htbd_pkg and htbd_entry_ram.
`default_nettype none

module htbd_ctrl #(
   parameter int TABLE_DEPTH  = htbd_pkg::TABLE_DEPTH_DEF,
   parameter int MAX_CODE_LEN = htbd_pkg::MAX_CODE_LEN_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   htbd_req_if.sink              req_ch,
   input  wire logic             slot_free,
   output logic                  res_push,
   output htbd_pkg::result_type  res_ff
);
   import htbd_pkg::*;

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int LEN_W = $clog2(MAX_CODE_LEN + 1);
   localparam int CMP_W = (LEN_W > ELEN_W) ? LEN_W : ELEN_W;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [IDX_W-1:0]  scan_ff, scan_in;
   logic [CODE_W-1:0] bits_ff, bits_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   result_type        res_in;

   logic              wr_en;
   entry_type         wr_data;
   logic [IDX_W-1:0]  rd_addr;
   entry_type         rd_data_ff;

   logic [CNT_W-1:0]  cnt_dec;
   logic [CODE_W-1:0] bits_next;
   logic [LEN_W-1:0]  len_next;
   logic              hit;
   logic              accept;

   htbd_entry_ram #(.TABLE_DEPTH(TABLE_DEPTH)) u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (count_ff[IDX_W-1:0]),
      .wr_data   (wr_data),
      .rd_addr   (rd_addr),
      .rd_data_ff(rd_data_ff)
   );

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign res_push     = (state_ff == ST_DONE) && slot_free;
   assign cnt_dec      = count_ff - CNT_W'(1);
   assign bits_next    = {bits_ff[CODE_W-2:0], req_ch.code_bit};
   assign len_next     = len_ff + LEN_W'(1);
   assign hit = (CMP_W'(rd_data_ff.length) == CMP_W'(len_ff)) &&
                (((rd_data_ff.code ^ bits_ff) & code_mask(rd_data_ff.length)) == '0);

   assign wr_data.symbol = req_ch.entry_symbol;
   assign wr_data.length = req_ch.entry_length;
   assign wr_data.code   = req_ch.entry_code;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      scan_in  = scan_ff;
      bits_in  = bits_ff;
      len_in   = len_ff;
      res_in   = res_ff;
      wr_en    = 1'b0;
      rd_addr  = cnt_dec[IDX_W-1:0];
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               res_in   = '0;
               state_in = ST_DONE;
               case (command_type'(req_ch.command))
                  CMD_LOAD: begin
                     if (count_ff >= CNT_W'(TABLE_DEPTH)) begin
                        res_in.table_full = 1'b1;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  CMD_DECODE: begin
                     bits_in = bits_next;
                     len_in  = len_next;
                     if (count_ff != '0) begin
                        scan_in  = cnt_dec[IDX_W-1:0];
                        state_in = ST_SCAN;
                     end else if (len_next >= LEN_W'(MAX_CODE_LEN)) begin
                        res_in.code_overflow = 1'b1;
                        bits_in              = '0;
                        len_in               = '0;
                     end
                  end
                  CMD_CLEAR: begin
                     count_in = '0;
                     bits_in  = '0;
                     len_in   = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            rd_addr = scan_ff - IDX_W'(1);
            if (hit) begin
               res_in.symbol_valid   = 1'b1;
               res_in.decoded_symbol = rd_data_ff.symbol;
               bits_in               = '0;
               len_in                = '0;
               state_in              = ST_DONE;
            end else if (scan_ff == '0) begin
               if (len_ff >= LEN_W'(MAX_CODE_LEN)) begin
                  res_in.code_overflow = 1'b1;
                  bits_in              = '0;
                  len_in               = '0;
               end
               state_in = ST_DONE;
            end else begin
               scan_in = scan_ff - IDX_W'(1);
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         bits_ff  <= '0;
         len_ff   <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         bits_ff  <= bits_in;
         len_ff   <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff <= scan_in;
      res_ff  <= res_in;
   end

endmodule

`default_nettype wire

[src/huffman_table_bit_decoder.sv]
// Bit-serial prefix-code decoder with a loadable code table. Commands load a table
// entry, decode one stream bit or clear the table and accumulator; every command
// gives exactly one result word. One command is in work at a time. Load, clear and
// unused commands go straight to the result; a decode with a non-empty table scans
// the entry memory from the newest entry down, one read per cycle, and stops at the
// first match. A finished result sits in an output register, so the next command
// is taken while it waits. Depends on htbd_pkg, the channel interfaces and
// htbd_ctrl.
`default_nettype none

module huffman_table_bit_decoder #(
   parameter int TABLE_DEPTH  = htbd_pkg::TABLE_DEPTH_DEF,
   parameter int MAX_CODE_LEN = htbd_pkg::MAX_CODE_LEN_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   htbd_req_if.sink   req_ch,
   htbd_rsp_if.source rsp_ch
);
   import htbd_pkg::*;

   logic       out_valid_ff, out_valid_in;
   result_type out_res_ff;
   result_type res_ff;
   logic       res_push;
   logic       slot_free;

   htbd_ctrl #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .MAX_CODE_LEN(MAX_CODE_LEN)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .slot_free(slot_free),
      .res_push (res_push),
      .res_ff   (res_ff)
   );

   assign slot_free    = !out_valid_ff || rsp_ch.ready;
   assign out_valid_in = res_push || (out_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_push) begin
         out_res_ff <= res_ff;
      end
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.symbol_valid   = out_res_ff.symbol_valid;
   assign rsp_ch.decoded_symbol = out_res_ff.decoded_symbol;
   assign rsp_ch.code_overflow  = out_res_ff.code_overflow;
   assign rsp_ch.table_full     = out_res_ff.table_full;

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      res_push |-> slot_free)
      else $error("result pushed into an occupied output register");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("second word accepted while a command is in work");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |->
         ($countones({rsp_ch.symbol_valid, rsp_ch.code_overflow, rsp_ch.table_full}) <= 1))
      else $error("more than one result flag set");

   a_push_fills: assert property (@(posedge clock) disable iff (reset)
      res_push |=> rsp_ch.valid)
      else $error("pushed result not presented");

endmodule

`default_nettype wire
